[rtl/core/att_pkg.sv]
// Shared types and constants for the alarm timer table.
// Holds the request/result payloads and the controller-datapath command/status structs.
// No dependencies.
package att_pkg;

   localparam int DEF_NUM_SLOTS  = 4;
   localparam int DEF_NUM_EVENTS = 16;

   localparam int EVENT_W = 4;
   localparam int COUNT_W = 31;
   localparam int AUX_W   = 32;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [EVENT_W-1:0] event_id;
      logic               periodic;
      logic [COUNT_W-1:0] delay_ticks;
      logic [AUX_W-1:0]   aux_data;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] fired_event;
      logic [AUX_W-1:0]   fired_aux;
      logic               overflow;
      logic               last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic do_set;
      logic do_scan;
      logic do_flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic scan_fire;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

[rtl/core/att_ctrl.sv]
// Controller state machine for the alarm timer table.
// Sequences accept, set, slot scan and result flush; depends on att_pkg.
module att_ctrl #(
   parameter int NUM_SLOTS = att_pkg::DEF_NUM_SLOTS,
   parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  att_pkg::sts_type  sts,
   output att_pkg::cmd_type  cmd,
   output logic [SW-1:0]     slot_idx
);
   import att_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SET   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic          step;

   assign req_stall = (state_ff != ST_IDLE);
   assign slot_idx  = idx_ff;

   // A scan step waits only when a second result must displace a pending one
   // and the output register cannot take it.
   assign step = !(sts.scan_fire && sts.pend_valid && !sts.out_free);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SET;
            end
         end
         ST_SET: begin
            if (sts.is_tick) begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cmd.do_set = 1'b1;
               state_in   = ST_FLUSH;
            end
         end
         ST_SCAN: begin
            if (step) begin
               cmd.do_scan = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.do_flush = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[rtl/core/att_dpath.sv]
// Datapath for the alarm timer table: slot table, event map, pending and output registers.
// Acts on commands from att_ctrl; depends on att_pkg.
module att_dpath #(
   parameter int NUM_SLOTS  = att_pkg::DEF_NUM_SLOTS,
   parameter int NUM_EVENTS = att_pkg::DEF_NUM_EVENTS,
   parameter int SW         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  att_pkg::req_type  req_data,
   input  att_pkg::cmd_type  cmd,
   input  logic [SW-1:0]     slot_idx,
   output att_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output att_pkg::rsp_type  rsp_data
);
   import att_pkg::*;

   localparam int EW = $clog2(NUM_EVENTS);

   // Slot table.
   logic               slot_busy_ff    [NUM_SLOTS];
   logic               slot_busy_in    [NUM_SLOTS];
   logic               slot_repeats_ff [NUM_SLOTS];
   logic               slot_repeats_in [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_count_ff   [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_count_in   [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_period_ff  [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_period_in  [NUM_SLOTS];
   logic [EVENT_W-1:0] slot_event_ff   [NUM_SLOTS];
   logic [EVENT_W-1:0] slot_event_in   [NUM_SLOTS];
   logic [AUX_W-1:0]   slot_aux_ff     [NUM_SLOTS];
   logic [AUX_W-1:0]   slot_aux_in     [NUM_SLOTS];

   // Event to slot map.
   logic               map_valid_ff [NUM_EVENTS];
   logic               map_valid_in [NUM_EVENTS];
   logic [SW-1:0]      map_slot_ff  [NUM_EVENTS];
   logic [SW-1:0]      map_slot_in  [NUM_EVENTS];

   req_type            req_ff, req_in;
   rsp_type            pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               ev_ok;
   logic [EW-1:0]      ev_idx;
   logic               hit;
   logic [SW-1:0]      hit_slot;
   logic               free_found;
   logic [SW-1:0]      free_slot;
   logic               is_clear;
   logic [COUNT_W-1:0] cnt_next;
   logic               fire;
   logic               out_free;
   logic               push;
   rsp_type            push_data;
   rsp_type            fire_res;

   assign ev_ok    = (32'(req_ff.event_id) < NUM_EVENTS);
   assign ev_idx   = EW'(req_ff.event_id);
   assign hit      = ev_ok && map_valid_ff[ev_idx];
   assign hit_slot = map_slot_ff[ev_idx];
   assign is_clear = (req_ff.delay_ticks == '0) && !req_ff.periodic;

   assign cnt_next = slot_count_ff[slot_idx] + 1'b1;
   assign fire     = slot_busy_ff[slot_idx] && (cnt_next >= slot_period_ff[slot_idx]);
   assign out_free = !out_valid_ff || !rsp_stall;

   assign sts.is_tick    = (req_ff.kind == KIND_TICK);
   assign sts.scan_fire  = fire;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   always_comb begin
      fire_res.fired_event = slot_event_ff[slot_idx];
      fire_res.fired_aux   = slot_aux_ff[slot_idx];
      fire_res.overflow    = 1'b0;
      fire_res.last        = 1'b0;
   end

   always_comb begin
      slot_busy_in    = slot_busy_ff;
      slot_repeats_in = slot_repeats_ff;
      slot_count_in   = slot_count_ff;
      slot_period_in  = slot_period_ff;
      slot_event_in   = slot_event_ff;
      slot_aux_in     = slot_aux_ff;
      map_valid_in    = map_valid_ff;
      map_slot_in     = map_slot_ff;
      req_in          = req_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      push            = 1'b0;
      push_data       = pend_ff;

      if (cmd.load) begin
         req_in = req_data;
      end

      if (cmd.do_set && ev_ok) begin
         if (is_clear) begin
            if (hit) begin
               map_valid_in[ev_idx]      = 1'b0;
               slot_busy_in[hit_slot]    = 1'b0;
               slot_repeats_in[hit_slot] = 1'b0;
               slot_count_in[hit_slot]   = '0;
               slot_event_in[hit_slot]   = '0;
               slot_aux_in[hit_slot]     = '0;
            end
         end else if (hit) begin
            slot_count_in[hit_slot]   = '0;
            slot_aux_in[hit_slot]     = req_ff.aux_data;
            slot_repeats_in[hit_slot] = req_ff.periodic;
            slot_period_in[hit_slot]  = req_ff.delay_ticks;
         end else if (free_found) begin
            slot_busy_in[free_slot]    = 1'b1;
            slot_event_in[free_slot]   = req_ff.event_id;
            slot_aux_in[free_slot]     = req_ff.aux_data;
            slot_repeats_in[free_slot] = req_ff.periodic;
            slot_period_in[free_slot]  = req_ff.delay_ticks;
            map_valid_in[ev_idx]       = 1'b1;
            map_slot_in[ev_idx]        = free_slot;
         end else begin
            pend_in.fired_event = '0;
            pend_in.fired_aux   = '0;
            pend_in.overflow    = 1'b1;
            pend_in.last        = 1'b0;
            pend_valid_in       = 1'b1;
         end
      end

      if (cmd.do_scan && slot_busy_ff[slot_idx]) begin
         if (fire) begin
            // A newer result proves the pending one is not the last.
            if (pend_valid_ff) begin
               push           = 1'b1;
               push_data      = pend_ff;
               push_data.last = 1'b0;
            end
            pend_in       = fire_res;
            pend_valid_in = 1'b1;
            if (slot_repeats_ff[slot_idx]) begin
               slot_count_in[slot_idx] = '0;
            end else begin
               map_valid_in[EW'(slot_event_ff[slot_idx])] = 1'b0;
               slot_busy_in[slot_idx]    = 1'b0;
               slot_repeats_in[slot_idx] = 1'b0;
               slot_count_in[slot_idx]   = '0;
               slot_event_in[slot_idx]   = '0;
               slot_aux_in[slot_idx]     = '0;
            end
         end else begin
            slot_count_in[slot_idx] = cnt_next;
         end
      end

      if (cmd.do_flush) begin
         push           = 1'b1;
         push_data      = pend_ff;
         push_data.last = 1'b1;
         pend_valid_in  = 1'b0;
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (push) begin
         out_in       = push_data;
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_busy_ff[i]    <= 1'b0;
            slot_repeats_ff[i] <= 1'b0;
            slot_count_ff[i]   <= '0;
            slot_event_ff[i]   <= '0;
            slot_aux_ff[i]     <= '0;
         end
         for (int e = 0; e < NUM_EVENTS; e++) begin
            map_valid_ff[e] <= 1'b0;
         end
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_busy_ff    <= slot_busy_in;
         slot_repeats_ff <= slot_repeats_in;
         slot_count_ff   <= slot_count_in;
         slot_event_ff   <= slot_event_in;
         slot_aux_ff     <= slot_aux_in;
         map_valid_ff    <= map_valid_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      slot_period_ff <= slot_period_in;
      map_slot_ff    <= map_slot_in;
      req_ff         <= req_in;
      pend_ff        <= pend_in;
      out_ff         <= out_in;
   end

endmodule

[rtl/core/alarm_timer_table_unit.sv]
// Alarm timer table, top level. A tick request is decoded, then the scan loop visits one slot
// per cycle, then the last result is flushed and the controller returns to idle before the
// next request can be accepted. A set request is applied on decode and then flushed the same way.
// Either one takes longer only while rsp_stall keeps a result in the output register when
// another result has to move into it.
// Synchronous reset frees every slot and marks every event as having no alarm at once.
module alarm_timer_table_unit #(
   parameter int NUM_SLOTS  = att_pkg::DEF_NUM_SLOTS,
   parameter int NUM_EVENTS = att_pkg::DEF_NUM_EVENTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  att_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output att_pkg::rsp_type  rsp_data
);
   import att_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // The controller walks the request through load, set or scan, and flush. The
   // datapath owns all state; during a tick scan it keeps the newest fired result
   // pending so that the last flag can be set once the scan has ended.
   // Results leave through an output register, so a new request is taken while one waits.
   cmd_type       cmd;
   sts_type       sts;
   logic [SW-1:0] slot_idx;

   att_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .SW        (SW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .slot_idx  (slot_idx)
   );

   att_dpath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_EVENTS (NUM_EVENTS),
      .SW         (SW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .slot_idx  (slot_idx),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/alarm_timer_table_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the alarm timer table: it watches both channels, models the slot table and
// compares every result with the oldest expected one. Depends on att_pkg.
module alarm_timer_table_checker #(
   parameter int NUM_SLOTS  = att_pkg::DEF_NUM_SLOTS,
   parameter int NUM_EVENTS = att_pkg::DEF_NUM_EVENTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  att_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  att_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               mismatches
);
   import att_pkg::*;

   logic               slot_busy    [NUM_SLOTS];
   logic               slot_repeats [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_count   [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_period  [NUM_SLOTS];
   logic [EVENT_W-1:0] slot_owner   [NUM_SLOTS];
   logic [AUX_W-1:0]   slot_aux     [NUM_SLOTS];
   logic               event_armed  [NUM_EVENTS];
   int                 event_slot   [NUM_EVENTS];

   rsp_type fired_q[$];
   rsp_type held_result;
   logic    result_held;
   int      error_total;

   function automatic void release_slot(int s);
      slot_busy[s]    = 1'b0;
      slot_repeats[s] = 1'b0;
      slot_count[s]   = '0;
      slot_owner[s]   = '0;
      slot_aux[s]     = '0;
   endfunction

   // The newest result is held back until the request is done, so that it can be marked last.
   function automatic void queue_result(logic [EVENT_W-1:0] ev, logic [AUX_W-1:0] aux,
                                        logic ovf);
      if (result_held) begin
         fired_q.push_back(held_result);
      end
      held_result.fired_event = ev;
      held_result.fired_aux   = aux;
      held_result.overflow    = ovf;
      held_result.last        = 1'b0;
      result_held             = 1'b1;
   endfunction

   function automatic void predict_request(req_type r);
      int s;
      int free_s;
      if (r.kind == KIND_TICK) begin
         for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_busy[s]) begin
               slot_count[s] = slot_count[s] + 1'b1;
               if (slot_count[s] >= slot_period[s]) begin
                  queue_result(slot_owner[s], slot_aux[s], 1'b0);
                  if (slot_repeats[s]) begin
                     slot_count[s] = '0;
                  end else begin
                     event_armed[slot_owner[s]] = 1'b0;
                     release_slot(s);
                  end
               end
            end
         end
      end else if (r.delay_ticks == '0 && !r.periodic) begin
         if (event_armed[r.event_id]) begin
            event_armed[r.event_id] = 1'b0;
            release_slot(event_slot[r.event_id]);
         end
      end else if (event_armed[r.event_id]) begin
         s = event_slot[r.event_id];
         slot_count[s]   = '0;
         slot_aux[s]     = r.aux_data;
         slot_repeats[s] = r.periodic;
         slot_period[s]  = r.delay_ticks;
      end else begin
         free_s = -1;
         for (s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!slot_busy[s]) begin
               free_s = s;
            end
         end
         if (free_s >= 0) begin
            slot_busy[free_s]      = 1'b1;
            slot_owner[free_s]     = r.event_id;
            slot_aux[free_s]       = r.aux_data;
            slot_repeats[free_s]   = r.periodic;
            slot_period[free_s]    = r.delay_ticks;
            slot_count[free_s]     = '0;
            event_armed[r.event_id] = 1'b1;
            event_slot[r.event_id]  = free_s;
         end else begin
            queue_result('0, '0, 1'b1);
         end
      end
      if (result_held) begin
         held_result.last = 1'b1;
         fired_q.push_back(held_result);
         result_held = 1'b0;
      end
   endfunction

   function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < NUM_SLOTS; i++) begin
            release_slot(i);
            slot_period[i] = '0;
         end
         for (i = 0; i < NUM_EVENTS; i++) begin
            event_armed[i] = 1'b0;
            event_slot[i]  = 0;
         end
         fired_q.delete();
         result_held = 1'b0;
         error_total = 0;
      end else begin
         // Results always belong to requests taken at earlier edges, so check before predicting.
         if (rsp_valid && !rsp_stall) begin
            if (fired_q.size() == 0) begin
               $display("%0t: result with nothing expected: event %h aux %h overflow %b last %b",
                        $time, rsp_data.fired_event, rsp_data.fired_aux, rsp_data.overflow,
                        rsp_data.last);
               error_total++;
            end else begin
               want = fired_q.pop_front();
               error_total += field_differs("fired_event", 32'(want.fired_event),
                                            32'(rsp_data.fired_event));
               error_total += field_differs("fired_aux", want.fired_aux, rsp_data.fired_aux);
               error_total += field_differs("overflow", 32'(want.overflow),
                                            32'(rsp_data.overflow));
               error_total += field_differs("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_request(req_data);
         end
      end
      outstanding <= fired_q.size();
      mismatches  <= error_total;
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the alarm timer table testbench: clock, reset, request traffic and result-side stalls.
// Depends on att_pkg, alarm_timer_table_unit and alarm_timer_table_checker.
module testbench;
   import att_pkg::*;

   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 LONG_HOLD      = 150;
   localparam int                 RANDOM_PHASES  = 6;
   localparam int                 PHASE_ITEMS    = 72;
   localparam int                 SETTLE_CYCLES  = 4 * (DEF_NUM_SLOTS + 2);
   localparam logic [COUNT_W-1:0] MAX_DELAY      = 31'h7fff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      outstanding;
   int      mismatches;
   int      idle_cycles = 0;

   // Shared between the request and result processes: no_idle turns off all random gaps,
   // and hold_request asks the result side for one long hold-off.
   bit      no_idle      = 1'b0;
   bit      hold_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   alarm_timer_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   alarm_timer_table_checker table_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // The watchdog only counts cycles in which neither channel moves anything. The longest
   // legal quiet stretch is the deliberate result hold-off, far below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired after %0d cycles without a handshake", $time,
                  idle_cycles);
         $display("[alarm_timer_table_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request. A random gap goes first unless gaps are turned off; the payload then
   // stays put until the block takes the request. Returns at the falling edge after acceptance,
   // so valid stays high into the next request when there is no gap.
   task automatic send_request(req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // A tick ignores every field but its kind, so the rest carries random bits.
   task automatic send_tick();
      req_type item;
      item.kind        = KIND_TICK;
      item.event_id    = EVENT_W'($urandom_range(0, 15));
      item.periodic    = 1'($urandom_range(0, 1));
      item.delay_ticks = COUNT_W'($urandom);
      item.aux_data    = $urandom;
      send_request(item);
   endtask

   // A set request with zero delay and no repeat flag clears the event's alarm.
   task automatic set_alarm(logic [EVENT_W-1:0] ev, logic rep, logic [COUNT_W-1:0] delay,
                            logic [AUX_W-1:0] aux);
      req_type item;
      item.kind        = KIND_SET;
      item.event_id    = ev;
      item.periodic    = rep;
      item.delay_ticks = delay;
      item.aux_data    = aux;
      send_request(item);
   endtask

   // Half of the random requests are ticks. Set requests favor a few events so that re-arming
   // and clearing happen often, and mostly use short delays so that alarms actually fire; a
   // few long delays keep slots busy and push the table into overflow.
   task automatic send_random_request();
      int                 pick;
      logic [EVENT_W-1:0] ev;
      logic [COUNT_W-1:0] delay;
      logic               rep;
      if ($urandom_range(0, 1) == 0) begin
         send_tick();
      end else begin
         pick = $urandom_range(0, 99);
         ev   = ($urandom_range(0, 9) < 7) ? EVENT_W'($urandom_range(0, 5))
                                           : EVENT_W'($urandom_range(0, 15));
         rep  = 1'($urandom_range(0, 1));
         if (pick < 15) begin
            rep   = 1'b0;
            delay = '0;
         end else if (pick < 19) begin
            delay = COUNT_W'($urandom);
         end else if (pick < 21) begin
            delay = MAX_DELAY;
         end else begin
            delay = COUNT_W'($urandom_range(0, 5));
         end
         set_alarm(ev, rep, delay, $urandom);
      end
   endtask

   // Stops offering and waits until the scoreboard has seen every expected result.
   task automatic wait_all_fired();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      @(negedge clock);
   endtask

   // Result side: a random stall before each result, none while gaps are off, and one long
   // hold-off when the request side asks for it. The hold-off is counted here, in cycles.
   initial begin : result_side
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold         = LONG_HOLD;
            hold_request = 1'b0;
         end else if (no_idle) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 7);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin : request_side
      int phase;
      int n;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A tick on the empty table and a clear of an event that has no alarm
      // must both stay silent.
      send_tick();
      set_alarm(4'd3, 1'b0, '0, 32'h0000_0000);
      // Fill all four slots: a one-shot due on the next tick, a periodic alarm with period
      // zero that fires on every tick, one that never comes due, and a periodic one of two.
      set_alarm(4'd0, 1'b0, 31'd1, 32'hffff_ffff);
      set_alarm(4'd15, 1'b1, '0, 32'ha5a5_a5a5);
      set_alarm(4'd7, 1'b0, MAX_DELAY, 32'h0000_0000);
      set_alarm(4'd9, 1'b1, 31'd2, 32'h5a5a_5a5a);
      // No slot is free, so this one must come back as an overflow.
      set_alarm(4'd4, 1'b0, 31'd3, 32'h0000_0001);
      send_tick();
      send_tick();
      // Re-arm two existing alarms and take the slot that the one-shot left behind; the next
      // tick then fires every slot at once.
      set_alarm(4'd9, 1'b1, 31'd1, 32'h1234_5678);
      set_alarm(4'd4, 1'b1, 31'd1, 32'h8000_0000);
      set_alarm(4'd7, 1'b0, 31'd1, 32'hdead_beef);
      send_tick();
      // Clear what is left, then a tick must find nothing.
      set_alarm(4'd15, 1'b0, '0, 32'hffff_ffff);
      set_alarm(4'd9, 1'b0, '0, 32'h0000_0000);
      set_alarm(4'd4, 1'b0, '0, 32'h0000_0000);
      send_tick();
      set_alarm(4'd1, 1'b1, 31'h4000_0000, 32'h0f0f_0f0f);
      set_alarm(4'd1, 1'b0, '0, 32'h0000_0000);
      wait_all_fired();

      // Random phases. One runs without any gaps, and one also asks the result side for a long
      // hold-off while requests keep coming back to back, so that the block backs up into its
      // request port. Between phases the sender waits until every result is in.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle = (phase == 1) || (phase == 3);
         if (phase == 3) begin
            hold_request = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request();
         end
         wait_all_fired();
      end

      // Let any stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[alarm_timer_table_unit] OK");
      end else begin
         $display("[alarm_timer_table_unit] ERROR");
      end
      $finish;
   end

endmodule
